FILE: rtl/pcft_pkg.sv
// shared types, widths and saturation helper for the principal curvature pipeline
package pcft_pkg;

  localparam int unsigned DataW     = 32;               // q16.16 word
  localparam int unsigned SumW      = DataW + 1;        // e + g
  localparam int unsigned ProdW     = 2 * DataW;        // 32x32 products
  localparam int unsigned RadW      = ProdW + 2;        // 4f^2 + (e-g)^2
  localparam int unsigned SqrtSteps = RadW / 2;         // one root bit per stage
  localparam int unsigned RootW     = SqrtSteps;
  localparam int unsigned RemW      = RootW + 3;
  localparam int unsigned DetW      = ProdW + 1;
  localparam int unsigned FracW     = 16;
  localparam int unsigned SatInW    = DetW - FracW;     // widest value to clamp
  localparam int unsigned InTdataW  = 3 * DataW;
  localparam int unsigned OutBitsW  = 4 * DataW + 1;
  localparam int unsigned OutTdataW = ((OutBitsW + 7) / 8) * 8;
  // input register, product stage, sqrt input, sqrt stages, final stage
  localparam int unsigned NumStages = 3 + SqrtSteps + 1;

  localparam logic signed [DataW-1:0] SatMax = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] SatMin = {1'b1, {(DataW-1){1'b0}}};

  typedef struct packed {
    logic signed [SumW-1:0]  sum;
    logic        [DataW-1:0] adiff;
    logic signed [DataW-1:0] e;
    logic signed [DataW-1:0] f;
    logic signed [DataW-1:0] g;
  } stg_a_t;

  typedef struct packed {
    logic signed [SumW-1:0]  sum;
    logic        [ProdW-1:0] fsq;
    logic        [ProdW-1:0] dsq;
    logic signed [ProdW-1:0] eg;
  } stg_b_t;

  typedef struct packed {
    logic        [RadW-1:0]  rad;
    logic        [RemW-1:0]  rem;
    logic        [RootW-1:0] root;
    logic signed [SumW-1:0]  sum;
    logic signed [DataW-1:0] gauss;
    logic                    govf;
  } sq_t;

  typedef struct packed {
    logic                    ovf;
    logic signed [DataW-1:0] gauss;
    logic signed [DataW-1:0] mean;
    logic signed [DataW-1:0] cmin;
    logic signed [DataW-1:0] cmax;
  } res_t;

  typedef struct packed {
    logic                    ovf;
    logic signed [DataW-1:0] val;
  } sat_t;

  // clamp a wide signed value into the q16.16 range
  function automatic sat_t sat32(input logic signed [SatInW-1:0] x);
    sat_t r;
    logic [SatInW-DataW:0] top;
    top = x[SatInW-1:DataW-1];
    if ((&top) || !(|top)) begin
      r.ovf = 1'b0;
      r.val = x[DataW-1:0];
    end else begin
      r.ovf = 1'b1;
      r.val = x[SatInW-1] ? SatMin : SatMax;
    end
    return r;
  endfunction

endpackage

FILE: rtl/principal_curvature_from_tensor.sv
// principal curvature pipeline: eigenvalues, mean and gaussian of a symmetric 2x2 tensor
//
// Each input item carries the tensor entries e, f, g of [[e f][f g]] as signed
// q16.16 words. The block returns the larger and smaller eigenvalue
// floor((s +/- t) / 2) with s = e + g and t = floor(sqrt(4f^2 + (e-g)^2)), the
// mean floor(s / 2) and the gaussian floor((e*g - f*f) / 2^16). Eigenvalues
// and gaussian saturate to the q16.16 range and raise the overflow bit; the
// mean never saturates. All divisions by two and fraction drops round toward
// minus infinity, the root truncates. The block keeps no state between items
// and takes one item every cycle while s_axis_tready_o is high. From the
// accepting edge an item passes through one input register, one stage
// holding the three 32x32 multipliers, one stage forming the 66-bit radicand
// and the clamped gaussian, 33 square-root stages that each settle one root
// bit with a 36-bit compare and subtract, and one stage for the eigenvalue
// adds and clamps, followed by the output register. A skid register behind
// the output lets the pipeline keep taking items after the output stalls,
// until the skid register fills; s_axis_tready_o is a registered signal and
// drops only while that skid register is occupied.
module principal_curvature_from_tensor
  import pcft_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [InTdataW-1:0]  s_axis_tdata_i,   // tensor_e, tensor_f, tensor_g
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [OutTdataW-1:0] m_axis_tdata_o    // curv_max, curv_min, curv_mean,
                                                 // curv_gauss, overflow, zero pad
);

  // pipeline control: one valid bit per stage, the whole pipe moves together
  logic                 en;
  logic [NumStages-1:0] vld_q, vld_d;

  // stage payloads
  stg_a_t a_q, a_d;
  stg_b_t b_q, b_d;
  sq_t    sq_q [SqrtSteps+1];
  sq_t    sq0_d;
  res_t   fin_q, fin_d;

  // output register and skid
  res_t out_q, out_d, skid_q, skid_d;
  logic out_vld_q, out_vld_d, skid_vld_q, skid_vld_d;
  logic take, push;

  assign en              = !skid_vld_q;
  assign s_axis_tready_o = en;
  assign vld_d           = {vld_q[NumStages-2:0], s_axis_tvalid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  // stage a: unpack, trace sum and magnitude of the diagonal difference
  always_comb begin
    logic signed [SumW-1:0] diff;
    a_d.e   = s_axis_tdata_i[DataW-1:0];
    a_d.f   = s_axis_tdata_i[2*DataW-1:DataW];
    a_d.g   = s_axis_tdata_i[3*DataW-1:2*DataW];
    a_d.sum = SumW'(a_d.e) + SumW'(a_d.g);
    diff    = SumW'(a_d.e) - SumW'(a_d.g);
    a_d.adiff = diff[SumW-1] ? DataW'(-diff) : diff[DataW-1:0];
  end

  // stage b: the three products
  always_comb begin
    logic signed [ProdW-1:0] ff;
    ff      = a_q.f * a_q.f;
    b_d.sum = a_q.sum;
    b_d.fsq = ff;
    b_d.dsq = a_q.adiff * a_q.adiff;
    b_d.eg  = a_q.e * a_q.g;
  end

  // stage c: radicand and clamped gaussian
  always_comb begin
    logic signed [DetW-1:0] det;
    sat_t gs;
    det = $signed({b_q.eg[ProdW-1], b_q.eg}) - $signed({1'b0, b_q.fsq});
    gs  = sat32(det[DetW-1:FracW]);
    sq0_d.rad   = {b_q.fsq, 2'b00} + RadW'(b_q.dsq);
    sq0_d.rem   = '0;
    sq0_d.root  = '0;
    sq0_d.sum   = b_q.sum;
    sq0_d.gauss = gs.val;
    sq0_d.govf  = gs.ovf;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q      <= a_d;
      b_q      <= b_d;
      sq_q[0]  <= sq0_d;
    end
  end

  // square root, restoring form, one result bit per stage from the top
  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    localparam int unsigned Bit = SqrtSteps - 1 - k;
    logic [RemW-1:0] rem_sh, trial;
    logic            ge;
    sq_t             nxt_d;

    always_comb begin
      rem_sh = {sq_q[k].rem[RemW-3:0], sq_q[k].rad[2*Bit+1 -: 2]};
      trial  = {1'b0, sq_q[k].root, 2'b01};
      ge     = rem_sh >= trial;
      nxt_d      = sq_q[k];
      nxt_d.rem  = ge ? rem_sh - trial : rem_sh;
      nxt_d.root = {sq_q[k].root[RootW-2:0], ge};
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_q[k+1] <= nxt_d;
      end
    end
  end

  // final stage: eigenvalues and mean
  always_comb begin
    logic signed [SumW+1:0] up, dn;
    sat_t mx, mn;
    up = $signed({{2{sq_q[SqrtSteps].sum[SumW-1]}}, sq_q[SqrtSteps].sum})
       + $signed({2'b00, sq_q[SqrtSteps].root});
    dn = $signed({{2{sq_q[SqrtSteps].sum[SumW-1]}}, sq_q[SqrtSteps].sum})
       - $signed({2'b00, sq_q[SqrtSteps].root});
    // halve and sign-extend to the clamp width
    mx = sat32(SatInW'($signed(up[SumW+1:1])));
    mn = sat32(SatInW'($signed(dn[SumW+1:1])));
    fin_d.cmax  = mx.val;
    fin_d.cmin  = mn.val;
    fin_d.mean  = sq_q[SqrtSteps].sum[SumW-1:1];
    fin_d.gauss = sq_q[SqrtSteps].gauss;
    fin_d.ovf   = sq_q[SqrtSteps].govf | mx.ovf | mn.ovf;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fin_q <= fin_d;
    end
  end

  // output register with skid
  assign take = out_vld_q && m_axis_tready_i;
  assign push = en && vld_q[NumStages-1];

  always_comb begin
    out_d      = out_q;
    skid_d     = skid_q;
    out_vld_d  = out_vld_q && !take;
    skid_vld_d = skid_vld_q;
    if (push) begin
      out_vld_d = 1'b1;
      if (!out_vld_q || take) begin
        out_d = fin_q;
      end else begin
        skid_d     = fin_q;
        skid_vld_d = 1'b1;
      end
    end else if (skid_vld_q && take) begin
      out_d      = skid_q;
      out_vld_d  = 1'b1;
      skid_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = OutTdataW'(out_q);

  // the skid register only holds an item while the output register is full
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid item without output item");

  // skid fills only when the output was stalled
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_vld_q && !m_axis_tready_i))
    else $error("skid filled without stall");

  // a new output item comes from the last pipeline stage
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(en && vld_q[NumStages-1]))
    else $error("output item with no pipeline item behind it");

  // larger eigenvalue never below the smaller one
  a_eig_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.cmax >= out_q.cmin))
    else $error("curv_max below curv_min");

endmodule

FILE: tb/tb.sv
// testbench for the principal curvature pipeline: directed corners, random tensors, self-checking
`timescale 1ns / 100ps

module tb;
  import pcft_pkg::*;

  localparam int NumItems   = 1400;
  localparam int StallLimit = 4000;    // cycles with no item moving on either side
  localparam int DrainWait  = 60;      // beyond the pipeline depth plus skid

  localparam logic signed [DataW-1:0] QMax = SatMax;
  localparam logic signed [DataW-1:0] QMin = SatMin;
  localparam logic signed [DataW-1:0] One  = 32'sh0001_0000;

  // one row of the directed table; want is only meaningful when known is set
  typedef struct {
    logic signed [DataW-1:0] e;
    logic signed [DataW-1:0] f;
    logic signed [DataW-1:0] g;
    bit                      known;
    res_t                    want;   // '{ovf, gauss, mean, cmin, cmax}
  } tensor_row_t;

  localparam int NumDirected = 19;

  tensor_row_t corner_rows [NumDirected] = '{
    // all zero tensor
    '{32'sh0, 32'sh0, 32'sh0, 1'b1, '{1'b0, 32'sh0, 32'sh0, 32'sh0, 32'sh0}},
    // identity, both curvatures one
    '{One, 32'sh0, One, 1'b1, '{1'b0, One, One, One, One}},
    // all entries at the negative limit: min eigenvalue clamps, mean sits at the limit
    '{QMin, QMin, QMin, 1'b1, '{1'b1, 32'sh0, QMin, QMin, 32'sh0}},
    // diagonal at the positive limit: gaussian clamps high
    '{QMax, 32'sh0, QMax, 1'b1, '{1'b1, QMax, QMax, QMax, QMax}},
    // widest diagonal spread in both orders
    '{QMax, 32'sh0, QMin, 1'b0, '0},
    '{QMin, 32'sh0, QMax, 1'b0, '0},
    // pure off-diagonal at both limits: gaussian clamps, max eigenvalue too at the negative limit
    '{32'sh0, QMax, 32'sh0, 1'b0, '0},
    '{32'sh0, QMin, 32'sh0, 1'b0, '0},
    '{QMax, QMax, QMax, 1'b0, '0},
    '{QMin, QMax, QMax, 1'b0, '0},
    '{QMax, QMin, QMin, 1'b0, '0},
    // rounding toward minus infinity on odd sums
    '{-32'sh1, 32'sh0, 32'sh0, 1'b0, '0},
    '{32'sh1, 32'sh0, 32'sh0, 1'b0, '0},
    // root truncation and tiny negative gaussian
    '{32'sh0, 32'sh1, 32'sh0, 1'b0, '0},
    '{32'sh3, 32'sh1, 32'sh0, 1'b0, '0},
    '{32'sh0, -32'sh1, 32'sh0, 1'b0, '0},
    // ordinary mixed tensors
    '{One, QMax, -One, 1'b0, '0},
    '{-32'sh0020_0000, 32'sh0003_0000, 32'sh0005_8000, 1'b0, '0},
    '{32'sh0000_b505, -32'sh0001_6a0a, -32'sh7fff_0001, 1'b0, '0}
  };

  logic                 clk_i;
  logic                 rst_ni          = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [InTdataW-1:0]  s_axis_tdata_i  = '0;   // tensor_e, tensor_f, tensor_g
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata_o;         // curv_max, curv_min, curv_mean,
                                                // curv_gauss, overflow, zero pad

  // typed expectation that travels alongside the item on the input bus
  bit   tensor_known = 1'b0;
  res_t tensor_want  = '0;

  res_t pending_curv_q [$];
  int   mismatch_count = 0;
  int   stall_cycles   = 0;
  int   send_idle_pct  = 0;
  int   recv_idle_pct  = 0;

  principal_curvature_from_tensor dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // clamp a wide value into q16.16, flagging any clamp
  function automatic sat_t clamp_q16(longint x);
    sat_t c;
    c.ovf = 1'b0;
    c.val = x[DataW-1:0];
    if (x > 64'sd2147483647) begin
      c.ovf = 1'b1;
      c.val = QMax;
    end else if (x < -64'sd2147483648) begin
      c.ovf = 1'b1;
      c.val = QMin;
    end
    return c;
  endfunction

  // principal curvatures, mean and gaussian of [[e f][f g]]
  function automatic res_t predicted_curvature(logic signed [DataW-1:0] e_w,
                                               logic signed [DataW-1:0] f_w,
                                               logic signed [DataW-1:0] g_w);
    longint      e, f, g, s, d, t, det;
    logic [67:0] af, ad, rad, sq;
    logic [33:0] root, trial;
    sat_t        c;
    res_t        r;
    e = longint'(e_w);
    f = longint'(f_w);
    g = longint'(g_w);
    s = e + g;
    d = e - g;
    af = 68'((f < 0) ? -f : f);
    ad = 68'((d < 0) ? -d : d);
    rad = ((af * af) << 2) + ad * ad;
    // truncated root, one bit at a time from the top
    root = '0;
    for (int b = 33; b >= 0; b--) begin
      trial = root;
      trial[b] = 1'b1;
      sq = {34'd0, trial} * {34'd0, trial};
      if (sq <= rad) root = trial;
    end
    t = longint'({30'd0, root});
    r.ovf = 1'b0;
    c = clamp_q16((s + t) >>> 1);
    r.cmax = c.val;
    r.ovf |= c.ovf;
    c = clamp_q16((s - t) >>> 1);
    r.cmin = c.val;
    r.ovf |= c.ovf;
    r.mean = DataW'(s >>> 1);
    det = e * g - f * f;
    c = clamp_q16(det >>> 16);
    r.gauss = c.val;
    r.ovf |= c.ovf;
    return r;
  endfunction

  // one random q16.16 word, with a bias toward small values and corners
  function automatic logic signed [DataW-1:0] random_word();
    logic signed [DataW-1:0] w;
    case ($urandom_range(0, 3))
      0: w = $urandom;
      1: w = 32'($urandom_range(0, 32'd2097152)) - 32'd1048576;
      2: begin
        case ($urandom_range(0, 5))
          0: w = QMin;
          1: w = QMax;
          2: w = '0;
          3: w = '1;
          4: w = 32'sh1;
          default: w = $urandom;
        endcase
      end
      default: w = $signed(32'($urandom)) >>> $urandom_range(0, 31);
    endcase
    return w;
  endfunction

  // present one item, after a random gap, and hold it until taken
  task automatic send_tensor(logic signed [DataW-1:0] e, logic signed [DataW-1:0] f,
                             logic signed [DataW-1:0] g, bit known, res_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {g, f, e};
    tensor_known    <= known;
    tensor_want     <= want;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // receiver back-pressure
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // both handshakes are sampled here, result side first
  always @(posedge clk_i) begin
    res_t got, want;
    bit   moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        moved = 1'b1;
        got = res_t'(m_axis_tdata_o[OutBitsW-1:0]);
        if (pending_curv_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected item on output: %h", got);
        end else begin
          want = pending_curv_q.pop_front();
          if (got.cmax !== want.cmax || got.cmin !== want.cmin ||
              got.mean !== want.mean || got.gauss !== want.gauss ||
              got.ovf !== want.ovf) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch max %h/%h min %h/%h mean %h/%h gauss %h/%h ovf %b/%b",
                       want.cmax, got.cmax, want.cmin, got.cmin, want.mean, got.mean,
                       want.gauss, got.gauss, want.ovf, got.ovf);
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        moved = 1'b1;
        pending_curv_q.push_back(tensor_known ? tensor_want :
                                 predicted_curvature(s_axis_tdata_i[31:0],
                                                     s_axis_tdata_i[63:32],
                                                     s_axis_tdata_i[95:64]));
      end
    end
    stall_cycles <= moved ? 0 : stall_cycles + 1;
  end

  // watchdog on a stuck handshake
  initial begin
    wait (stall_cycles >= StallLimit);
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < NumItems; i++) begin
      // three idling phases: receiver sparse, sender sparse, then full rate
      case (i * 3 / NumItems)
        0: begin
          send_idle_pct = 31;
          recv_idle_pct = 74;
        end
        1: begin
          send_idle_pct = 74;
          recv_idle_pct = 31;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (i < NumDirected)
        send_tensor(corner_rows[i].e, corner_rows[i].f, corner_rows[i].g,
                    corner_rows[i].known, corner_rows[i].want);
      else
        send_tensor(random_word(), random_word(), random_word(), 1'b0, '0);
    end
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending_curv_q.size() != 0);
    // let any stray extra item show up
    repeat (DrainWait) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule

FILE: principal_curvature_from_tensor.f
rtl/pcft_pkg.sv
rtl/principal_curvature_from_tensor.sv
tb/tb.sv
